// ----- rtl/core/ssids_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSI directive scanner package
// Shared types, character codes and helpers for the directive scanner.
// ----------------------------------------------------------------------------
package ssids_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PFX_LEN_W = 3;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_ARG  = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  // One transfer group produced by one input byte: a replayed prefix then an optional tail.
  typedef struct packed {
    logic                 pfx_arg;
    logic [PFX_LEN_W-1:0] pfx_len;
    logic                 tail_vld;
    kind_e                tail_kind;
    logic [BYTE_W-1:0]    tail_byte;
  } desc_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic [BYTE_W-1:0] opener_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      2'd0:    ch = CH_LT;
      2'd1:    ch = CH_BANG;
      default: ch = CH_DASH;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ssids_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSI directive scanner front end
// Tracks the scan state and classifies each byte into at most one transfer group.
// ----------------------------------------------------------------------------
module ssids_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [ssids_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output ssids_pkg::desc_t               desc_o
);
  import ssids_pkg::*;

  typedef enum logic [9:0] {
    ST_BODY  = 10'b00_0000_0001,
    ST_LT    = 10'b00_0000_0010,
    ST_BANG  = 10'b00_0000_0100,
    ST_DASH1 = 10'b00_0000_1000,
    ST_DASH2 = 10'b00_0001_0000,
    ST_CMD   = 10'b00_0010_0000,
    ST_ARGS  = 10'b00_0100_0000,
    ST_QARGS = 10'b00_1000_0000,
    ST_CL1   = 10'b01_0000_0000,
    ST_CL2   = 10'b10_0000_0000
  } scan_state_e;

  scan_state_e       state_q, state_d;
  logic              accept;
  logic              body_run, args_run;
  logic [BYTE_W-1:0] c;
  desc_t             desc;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = data_byte_i;

  always_comb begin
    state_d        = state_q;
    body_run       = 1'b0;
    args_run       = 1'b0;
    desc.pfx_arg   = 1'b0;
    desc.pfx_len   = '0;
    desc.tail_vld  = 1'b0;
    desc.tail_kind = KIND_BODY;
    desc.tail_byte = c;
    case (state_q)
      ST_LT: begin
        if (c == CH_BANG) state_d = ST_BANG;
        else begin
          desc.pfx_len = 3'd1;
          body_run     = 1'b1;
        end
      end
      ST_BANG: begin
        if (c == CH_DASH) state_d = ST_DASH1;
        else begin
          desc.pfx_len = 3'd2;
          body_run     = 1'b1;
        end
      end
      ST_DASH1: begin
        if (c == CH_DASH) state_d = ST_DASH2;
        else begin
          desc.pfx_len = 3'd3;
          body_run     = 1'b1;
        end
      end
      ST_DASH2: begin
        if (c == CH_HASH) state_d = ST_CMD;
        else begin
          desc.pfx_len = 3'd4;
          body_run     = 1'b1;
        end
      end
      ST_CMD: begin
        if (is_space(c)) args_run = 1'b1;
        else begin
          desc.tail_vld  = 1'b1;
          desc.tail_kind = KIND_CMD;
        end
      end
      ST_ARGS: begin
        args_run = 1'b1;
      end
      ST_QARGS: begin
        if (c == CH_QUOTE) state_d = ST_ARGS;
        desc.tail_vld  = 1'b1;
        desc.tail_kind = KIND_ARG;
      end
      ST_CL1: begin
        if (c == CH_DASH) state_d = ST_CL2;
        else begin
          desc.pfx_arg = 1'b1;
          desc.pfx_len = 3'd1;
          args_run     = 1'b1;
        end
      end
      ST_CL2: begin
        if (c == CH_GT) begin
          desc.tail_vld  = 1'b1;
          desc.tail_kind = KIND_END;
          desc.tail_byte = CH_NUL;
          state_d        = ST_BODY;
        end else begin
          desc.pfx_arg = 1'b1;
          desc.pfx_len = 3'd2;
          args_run     = 1'b1;
        end
      end
      default: begin
        body_run = 1'b1;
      end
    endcase

    // Run the byte in the body or argument state, also to rerun it after a failed match.
    if (body_run) begin
      if (c == CH_LT) state_d = ST_LT;
      else begin
        state_d        = ST_BODY;
        desc.tail_vld  = 1'b1;
        desc.tail_kind = KIND_BODY;
      end
    end
    if (args_run) begin
      if (c == CH_DASH) state_d = ST_CL1;
      else begin
        state_d        = (c == CH_QUOTE) ? ST_QARGS : ST_ARGS;
        desc.tail_vld  = 1'b1;
        desc.tail_kind = KIND_ARG;
      end
    end
  end

  assign desc_o = desc;
  assign push_o = accept && (desc.tail_vld || (desc.pfx_len != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BODY;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("front pushed into a full queue");

  a_pfx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && desc.pfx_arg |-> (desc.pfx_len == 3'd1 || desc.pfx_len == 3'd2))
    else $error("dash replay of illegal length");

endmodule
`default_nettype wire

// ----- rtl/core/ssids_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSI directive scanner queue
// Short FIFO of transfer groups between the front and back ends.
// ----------------------------------------------------------------------------
module ssids_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ssids_pkg::desc_t desc_i,
  output logic                  full_o,
  output logic                  head_vld_o,
  output ssids_pkg::desc_t      head_o,
  input  wire logic             pop_i
);
  import ssids_pkg::*;

  desc_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_vld_o)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/core/ssids_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSI directive scanner back end
// Expands each transfer group into result transfers through an output register.
// ----------------------------------------------------------------------------
module ssids_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       head_vld_i,
  input  wire ssids_pkg::desc_t           head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [ssids_pkg::KIND_W-1:0]    kind_o,
  output logic [ssids_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                            last_o
);
  import ssids_pkg::*;

  logic [PFX_LEN_W-1:0] idx_q, idx_d;
  logic                 out_vld_q;
  kind_e                kind_q, kind_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic                 last_q, last_d;
  logic                 load;
  logic                 in_pfx;
  logic [PFX_LEN_W:0]   total;

  assign load   = head_vld_i && (!out_vld_q || !out_stall_i);
  assign in_pfx = (idx_q < head_i.pfx_len);
  assign total  = {1'b0, head_i.pfx_len} + {{PFX_LEN_W{1'b0}}, head_i.tail_vld};

  always_comb begin
    if (in_pfx) begin
      kind_d = head_i.pfx_arg ? KIND_ARG : KIND_BODY;
      byte_d = head_i.pfx_arg ? CH_DASH : opener_char(idx_q[1:0]);
    end else begin
      kind_d = head_i.tail_kind;
      byte_d = head_i.tail_byte;
    end
    last_d = ({1'b0, idx_q} + 1'b1) == total;
    idx_d  = last_d ? '0 : idx_q + 1'b1;
  end

  assign pop_o = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= idx_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

  a_mid_group_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> head_vld_i)
    else $error("partly sent group has left the queue");

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> idx_q <= head_i.pfx_len)
    else $error("group index past its prefix");

endmodule
`default_nettype wire

// ----- rtl/core/ssi_directive_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSI directive scanner
// Splits a document byte stream into body, command, argument and end transfers.
//
// Input channel: in_valid_i / in_stall_o with data_byte_i, one byte per transfer.
// Output channel: out_valid_o / out_stall_i with kind_o, out_byte_o, last_o.
// Each input byte yields zero to five result transfers; last_o marks the final
// one of a byte. Bytes that only advance an opener or close match yield none.
// Each byte's group enters the group queue when the byte is taken; its results
// then pass from the queue head through the output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver does not stall; a byte with more results holds the back end, and
// the input stalls once the two-entry group queue fills.
// Reset: scan state returns to body text, the queue empties, no result valid.
// When the receiver stalls, the held result stays stable and the queue keeps
// taking bytes until full.
// ----------------------------------------------------------------------------
module ssi_directive_scanner (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ssids_pkg::BYTE_W-1:0] data_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ssids_pkg::KIND_W-1:0]     kind_o,
  output logic [ssids_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                             last_o
);
  import ssids_pkg::*;

  logic  push, pop, q_full, head_vld;
  desc_t push_desc, head_desc;

  ssids_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  ssids_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .desc_i     (push_desc),
    .full_o     (q_full),
    .head_vld_o (head_vld),
    .head_o     (head_desc),
    .pop_i      (pop)
  );

  ssids_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire
